// ===== rtl/ttlog_pkg.sv =====
package ttlog_pkg;

    localparam int OPCODE_W   = 2;
    localparam int TASK_W     = 3;
    localparam int TIME_W     = 32;
    localparam int LOG_IDX_W  = 8;
    localparam int MEAN_W     = 31;
    localparam int COUNT_W    = 32;

    localparam int DIVIDEND_W = MEAN_W;
    localparam int DIVISOR_W  = COUNT_W;
    localparam int STEP_W     = $clog2(DIVIDEND_W);

    localparam logic [OPCODE_W-1:0] OP_RECORD     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ_LOG   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ_STATS = 2'd2;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] start_ts;
        logic [TIME_W-1:0] end_ts;
    } log_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [MEAN_W-1:0]  mean;
    } stat_entry_t;

    typedef struct packed {
        logic [TASK_W-1:0]    entry_task;
        logic [TIME_W-1:0]    entry_start;
        logic [TIME_W-1:0]    entry_end;
        logic [LOG_IDX_W-1:0] slot_used;
        logic [MEAN_W-1:0]    mean_ticks;
        logic [COUNT_W-1:0]   sample_count;
        logic                 error_flag;
    } result_t;

endpackage

// ===== rtl/task_timing_log_with_running_mean.sv =====
// Channel   Handshake            Beat contents
// request   req_valid/req_stall  opcode, task_number, start_time, end_time, log_index
// response  rsp_valid/rsp_stall  entry_task, entry_start, entry_end, slot_used,
//                                mean_ticks, sample_count, error_flag
//
// A read or a rejected request goes through the fetch and done states; a record also
// waits in the divide state for the 31-step bit-serial divider in the mean update.
// One request is in flight at a time; the next one is accepted once the
// response is loaded into the output register.
// Reset clears the control state, the statistics valid bits and the log fill count.
// A stalled response holds its beat; the block waits before loading the next one.
module task_timing_log_with_running_mean
    import ttlog_pkg::*;
#(
    parameter int LOG_DEPTH  = 256,
    parameter int TASK_SLOTS = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [TASK_W-1:0]    task_number,
    input  logic [TIME_W-1:0]    start_time,
    input  logic [TIME_W-1:0]    end_time,
    input  logic [LOG_IDX_W-1:0] log_index,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [TASK_W-1:0]    entry_task,
    output logic [TIME_W-1:0]    entry_start,
    output logic [TIME_W-1:0]    entry_end,
    output logic [LOG_IDX_W-1:0] slot_used,
    output logic [MEAN_W-1:0]    mean_ticks,
    output logic [COUNT_W-1:0]   sample_count,
    output logic                 error_flag
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int IDX_CNT = 2 ** LOG_IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [AW:0]           fill_reg, fill_next;
    logic [TASK_SLOTS-1:0] svld_reg, svld_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic [TASK_W-1:0]     id_reg, id_next;
    logic [TW-1:0]         t_reg, t_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [TIME_W-1:0]     end_reg, end_next;
    logic [MEAN_W-1:0]     dur_reg, dur_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic                  ok_reg, ok_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [MEAN_W-1:0]     mean_reg, mean_next;
    logic                  neg_reg, neg_next;
    result_t               pend_reg, pend_next;
    result_t               rsp_reg, rsp_next;

    logic [AW-1:0]         idx_tbl [IDX_CNT];
    logic                  accept;
    logic [TIME_W-1:0]     dur;
    logic                  id_ok;
    logic [TW-1:0]         t_in;

    log_entry_t            log_wdata, log_rdata, log_entry;
    logic                  log_we;
    stat_entry_t           stat_wdata, stat_rdata;
    logic                  stat_we;

    logic [COUNT_W-1:0]    cnt_old, cnt_inc;
    logic [MEAN_W-1:0]     mean_old, mean_new;
    logic [MEAN_W:0]       diff, mag, q_signed, mean_sum;

    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quot;

    for (genvar g = 0; g < IDX_CNT; g++)
    begin : g_idx
        assign idx_tbl[g] = AW'(g % LOG_DEPTH);
    end

    ttlog_ram #(
        .WIDTH ($bits(log_entry_t)),
        .DEPTH (LOG_DEPTH),
        .AW    (AW)
    ) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (wp_reg),
        .wdata (log_wdata),
        .raddr (idx_tbl[log_index]),
        .rdata (log_rdata)
    );

    ttlog_ram #(
        .WIDTH ($bits(stat_entry_t)),
        .DEPTH (TASK_SLOTS),
        .AW    (TW)
    ) u_stat_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (t_reg),
        .wdata (stat_wdata),
        .raddr (t_in),
        .rdata (stat_rdata)
    );

    ttlog_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag[DIVIDEND_W-1:0]),
        .divisor  (cnt_inc),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign dur       = end_time - start_time;
    assign id_ok     = (task_number != '0) && (32'(task_number) <= 32'(TASK_SLOTS));
    assign t_in      = TW'(task_number - 3'd1);

    assign log_wdata = '{task_id: id_reg, start_ts: start_reg, end_ts: end_reg};
    assign log_entry = ({1'b0, idx_reg} < fill_reg) ? log_rdata : '0;

    assign cnt_old  = svld_reg[t_reg] ? stat_rdata.count : '0;
    assign mean_old = svld_reg[t_reg] ? stat_rdata.mean : '0;
    assign cnt_inc  = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;
    assign diff     = {1'b0, dur_reg} - {1'b0, mean_old};
    assign mag      = diff[MEAN_W] ? (~diff + 1'b1) : diff;

    assign q_signed = neg_reg ? (~{1'b0, div_quot} + 1'b1) : {1'b0, div_quot};
    assign mean_sum = {1'b0, mean_reg} + q_signed;
    assign mean_new = mean_sum[MEAN_W-1:0];
    assign stat_wdata = '{count: cnt_reg, mean: mean_new};

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        svld_next      = svld_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        t_next         = t_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        dur_next       = dur_reg;
        idx_next       = idx_reg;
        ok_next        = ok_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        neg_next       = neg_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        log_we         = 1'b0;
        stat_we        = 1'b0;
        div_start      = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    id_next    = task_number;
                    t_next     = t_in;
                    start_next = start_time;
                    end_next   = end_time;
                    dur_next   = dur[MEAN_W-1:0];
                    idx_next   = idx_tbl[log_index];
                    case (opcode)
                        OP_RECORD:     ok_next = id_ok && !dur[TIME_W-1];
                        OP_READ_LOG:   ok_next = 1'b1;
                        OP_READ_STATS: ok_next = id_ok;
                        default:       ok_next = 1'b0;
                    endcase
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                pend_next            = '0;
                pend_next.error_flag = 1'b1;
                state_next           = S_DONE;
                if (ok_reg)
                begin
                    case (op_reg)
                        OP_RECORD:
                        begin
                            pend_next.error_flag   = 1'b0;
                            pend_next.entry_task   = id_reg;
                            pend_next.entry_start  = start_reg;
                            pend_next.entry_end    = end_reg;
                            pend_next.slot_used    = LOG_IDX_W'(wp_reg);
                            pend_next.sample_count = cnt_inc;
                            log_we     = 1'b1;
                            wp_next    = (wp_reg == AW'(LOG_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                            if (fill_reg != (AW + 1)'(LOG_DEPTH))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            cnt_next   = cnt_inc;
                            mean_next  = mean_old;
                            neg_next   = diff[MEAN_W];
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        OP_READ_LOG:
                        begin
                            pend_next.error_flag  = 1'b0;
                            pend_next.entry_task  = log_entry.task_id;
                            pend_next.entry_start = log_entry.start_ts;
                            pend_next.entry_end   = log_entry.end_ts;
                            pend_next.slot_used   = LOG_IDX_W'(idx_reg);
                        end
                        OP_READ_STATS:
                        begin
                            pend_next.error_flag   = 1'b0;
                            pend_next.mean_ticks   = mean_old;
                            pend_next.sample_count = cnt_old;
                        end
                        default:
                        begin
                            pend_next.error_flag = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    stat_we              = 1'b1;
                    svld_next[t_reg]     = 1'b1;
                    pend_next.mean_ticks = mean_new;
                    state_next           = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            svld_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            svld_reg      <= svld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        id_reg    <= id_next;
        t_reg     <= t_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        dur_reg   <= dur_next;
        idx_reg   <= idx_next;
        ok_reg    <= ok_next;
        cnt_reg   <= cnt_next;
        mean_reg  <= mean_next;
        neg_reg   <= neg_next;
        pend_reg  <= pend_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign entry_task   = rsp_reg.entry_task;
    assign entry_start  = rsp_reg.entry_start;
    assign entry_end    = rsp_reg.entry_end;
    assign slot_used    = rsp_reg.slot_used;
    assign mean_ticks   = rsp_reg.mean_ticks;
    assign sample_count = rsp_reg.sample_count;
    assign error_flag   = rsp_reg.error_flag;

endmodule

// ===== rtl/ttlog_ram.sv =====
module ttlog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ttlog_div.sv =====
module ttlog_div
    import ttlog_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            step_next = STEP_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
